FILE: sv/assert_macros.svh
// Assertion macros shared by the keycode queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked on every clock edge outside reset.
`define KQH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define KQH_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

FILE: sv/kqh_pkg.sv
// Package with the types, codes and helpers of the keycode queue.
package kqh_pkg;

    // Default number of queue slots; one slot always stays free.
    localparam int unsigned QUEUE_DEPTH_DEF = 16;

    // Fallback tick count after reset.
    localparam logic [15:0] FALLBACK_RESET = 16'd100;

    // Request type codes.
    localparam logic [1:0] REQ_KEY  = 2'd0;
    localparam logic [1:0] REQ_ACK  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // Control sequencer states.
    typedef enum logic {
        KQH_IDLE,
        KQH_FETCH
    } kqh_state_t;

    // One result transaction.
    typedef struct packed {
        logic       sent;
        logic [7:0] wire_byte;
        logic       dropped;
        logic       busy_res;
    } kqh_res_t;

    // The line byte is the code rotated left by one bit and then inverted.
    function automatic logic [7:0] wire_encode(input logic [7:0] code);
        wire_encode = ~{code[6:0], code[7]};
    endfunction

endpackage

FILE: sv/keycode_queue_with_handshake_unit.sv
// Keyboard transmitter: keycode ring queue with acknowledge handshake and fallback timer.
// Key codes, acknowledge samples and millisecond ticks enter as input transactions; each
// gives exactly one result transaction. The queue keeps QUEUE_DEPTH - 1 codes in a block
// RAM (its contents are not cleared at reset, and no clearing pass runs). An input that
// sends no code is answered from idle; one that sends a code takes the fetch state for
// the registered read of the queue RAM. The result sits in an output register, so a new
// transaction can be taken while the previous result is being collected. fallback_ticks
// resets to 100; the user must write it via cfg_we/cfg_wdata only when idle (unenforced).
module keycode_queue_with_handshake_unit #(
    parameter int unsigned QUEUE_DEPTH = kqh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_key_code,
    input  logic        s_ack_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_sent,
    output logic [7:0]  m_wire_byte,
    output logic        m_dropped,
    output logic        m_busy_res
);

    localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

    logic              out_free;
    logic              res_ld;
    kqh_pkg::kqh_res_t res;
    logic              ram_we;
    logic [PtrW-1:0]   ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [PtrW-1:0]   ram_raddr;
    logic [7:0]        ram_rdata;

    // Queue storage.
    kqh_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pointers, flags and countdown.
    kqh_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_key_code  (s_key_code),
        .s_ack_level (s_ack_level),
        .out_free    (out_free),
        .res_ld      (res_ld),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // Result channel register.
    kqh_outreg u_outreg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .res_ld      (res_ld),
        .res         (res),
        .out_free    (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sent      (m_sent),
        .m_wire_byte (m_wire_byte),
        .m_dropped   (m_dropped),
        .m_busy_res  (m_busy_res)
    );

endmodule

FILE: sv/kqh_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module kqh_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/kqh_ctrl.sv
// Queue pointers, handshake flags, fallback countdown and the fetch sequencer.
`include "assert_macros.svh"

module kqh_ctrl #(
    parameter int unsigned QUEUE_DEPTH = kqh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [15:0]                    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_req_type,
    input  logic [7:0]                     s_key_code,
    input  logic                           s_ack_level,
    input  logic                           out_free,
    output logic                           res_ld,
    output kqh_pkg::kqh_res_t              res,
    output logic                           ram_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
    output logic [7:0]                     ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
    input  logic [7:0]                     ram_rdata
);

    localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

    kqh_pkg::kqh_state_t state_reg, state_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic            awaiting_reg, awaiting_next;
    logic            armed_reg, armed_next;
    logic [15:0]     countdown_reg, countdown_next;
    logic [15:0]     fallback_ticks_reg;
    logic            fwd_reg, fwd_next;
    logic [7:0]      hold_reg, hold_next;

    logic            accept;
    logic            send;
    logic            dropped;
    logic [PtrW-1:0] rd_ptr_inc;
    logic [PtrW-1:0] wr_ptr_inc;

    // Ring pointers wrap at the last slot, so any depth works.
    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] ptr);
        ptr_inc = (ptr == PtrLast) ? '0 : ptr + 1'b1;
    endfunction

    assign rd_ptr_inc = ptr_inc(rd_ptr_reg);
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    assign ram_waddr = wr_ptr_reg;
    assign ram_wdata = s_key_code;
    assign ram_raddr = rd_ptr_reg;

    // Control registers and the fallback configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= kqh_pkg::KQH_IDLE;
            rd_ptr_reg         <= '0;
            wr_ptr_reg         <= '0;
            awaiting_reg       <= 1'b0;
            armed_reg          <= 1'b0;
            countdown_reg      <= '0;
            fallback_ticks_reg <= kqh_pkg::FALLBACK_RESET;
            fwd_reg            <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            awaiting_reg  <= awaiting_next;
            armed_reg     <= armed_next;
            countdown_reg <= countdown_next;
            fwd_reg       <= fwd_next;
            if (cfg_we) begin
                fallback_ticks_reg <= cfg_wdata;
            end
        end
    end

    // The held code for the forwarding path needs no reset.
    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
    end

    // Transaction decode, state update and result formation.
    always_comb begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        awaiting_next  = awaiting_reg;
        armed_next     = armed_reg;
        countdown_next = countdown_reg;
        fwd_next       = fwd_reg;
        hold_next      = hold_reg;
        send           = 1'b0;
        dropped        = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        res_ld         = 1'b0;
        res            = '0;
        s_ready        = 1'b0;
        accept         = 1'b0;

        unique case (state_reg)
            kqh_pkg::KQH_IDLE: begin
                s_ready = out_free;
                accept  = s_valid && out_free;
                if (accept) begin
                    unique case (s_req_type)
                        kqh_pkg::REQ_KEY: begin
                            if (wr_ptr_inc == rd_ptr_reg) begin
                                dropped = 1'b1;
                            end else begin
                                ram_we      = 1'b1;
                                wr_ptr_next = wr_ptr_inc;
                                if (!awaiting_reg) begin
                                    // An empty queue sends the code just written.
                                    send      = 1'b1;
                                    fwd_next  = (rd_ptr_reg == wr_ptr_reg);
                                    hold_next = s_key_code;
                                end
                            end
                        end
                        kqh_pkg::REQ_ACK: begin
                            if (s_ack_level && awaiting_reg) begin
                                awaiting_next = 1'b0;
                                send          = (rd_ptr_reg != wr_ptr_reg);
                                fwd_next      = 1'b0;
                            end
                        end
                        kqh_pkg::REQ_TICK: begin
                            if (armed_reg) begin
                                if (countdown_reg <= 16'd1) begin
                                    countdown_next = '0;
                                    armed_next     = 1'b0;
                                    awaiting_next  = 1'b0;
                                    send           = (rd_ptr_reg != wr_ptr_reg);
                                    fwd_next       = 1'b0;
                                end else begin
                                    countdown_next = countdown_reg - 16'd1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (send) begin
                        // Fetch the oldest code; the result follows next cycle.
                        rd_ptr_next    = rd_ptr_inc;
                        awaiting_next  = 1'b1;
                        countdown_next = fallback_ticks_reg;
                        armed_next     = 1'b1;
                        ram_re         = 1'b1;
                        state_next     = kqh_pkg::KQH_FETCH;
                    end else begin
                        res_ld       = 1'b1;
                        res.dropped  = dropped;
                        res.busy_res = awaiting_next;
                    end
                end
            end
            kqh_pkg::KQH_FETCH: begin
                res_ld        = 1'b1;
                res.sent      = 1'b1;
                res.wire_byte = kqh_pkg::wire_encode(fwd_reg ? hold_reg : ram_rdata);
                res.busy_res  = 1'b1;
                state_next    = kqh_pkg::KQH_IDLE;
            end
            default: begin
                state_next = kqh_pkg::KQH_IDLE;
            end
        endcase
    end

    `KQH_ASSERT(a_fetch_one_cycle, state_reg == kqh_pkg::KQH_FETCH |=> state_reg == kqh_pkg::KQH_IDLE, "fetch state held for more than one cycle")
    `KQH_ASSERT(a_wait_needs_countdown, awaiting_reg |-> armed_reg, "waiting for acknowledge without an armed countdown")
    `KQH_ASSERT(a_disarmed_is_zero, !armed_reg |-> countdown_reg == 16'd0, "disarmed countdown is not zero")
    `KQH_NEVER(a_no_write_while_fetch, ram_we && state_reg == kqh_pkg::KQH_FETCH, "queue written during a fetch")

endmodule

FILE: sv/kqh_outreg.sv
// Output register of the result channel.
`include "assert_macros.svh"

module kqh_outreg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_ld,
    input  kqh_pkg::kqh_res_t res,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_sent,
    output logic [7:0]        m_wire_byte,
    output logic              m_dropped,
    output logic              m_busy_res
);

    logic              m_valid_reg;
    kqh_pkg::kqh_res_t res_reg;

    // The slot is free when empty or when its transaction completes now.
    assign out_free = !m_valid_reg || m_ready;

    // Valid flag of the result slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (res_ld) begin
            res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_sent      = res_reg.sent;
    assign m_wire_byte = res_reg.wire_byte;
    assign m_dropped   = res_reg.dropped;
    assign m_busy_res  = res_reg.busy_res;

    `KQH_ASSERT(a_no_overwrite, res_ld |-> out_free, "result loaded over a pending transaction")
    `KQH_ASSERT(a_zero_when_idle_line, m_valid_reg && !res_reg.sent |-> res_reg.wire_byte == 8'd0, "line byte set without a send")

endmodule
